// File: rtl/v3alu_pkg.sv
// Package for the three-component vector unit: opcodes, constants,
// the structs that travel between pipeline sections, and a saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package v3alu_pkg;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_NEG    = 4'd2;
  localparam logic [3:0] OP_SCALE  = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_DOT    = 4'd5;
  localparam logic [3:0] OP_CROSS  = 4'd6;
  localparam logic [3:0] OP_LEN    = 4'd7;
  localparam logic [3:0] OP_NORMSQ = 4'd8;
  localparam logic [3:0] OP_SETLEN = 4'd9;
  localparam logic [3:0] OP_NORM   = 4'd10;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;

  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic        [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic        [31:0] S32_MIN = 32'h8000_0000;

  // Result fields as they ride down the pipe; r[0..2] are x, y, z.
  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      rs;
    logic             dz;
  } res_t;

  // Side data carried alongside the square root section.
  typedef struct packed {
    res_t             res;
    logic             use_div;
    logic             is_len;
    logic             is_vdiv;
    logic [4:0]       m;
    logic [2:0]       neg;
    logic [2:0][62:0] pm;
    logic [31:0]      ds;
  } sq_carry_t;

  // Side data carried alongside the divider section.
  typedef struct packed {
    res_t       res;
    logic       use_div;
    logic [2:0] neg;
  } dv_carry_t;

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    logic [31:0] o;
    if (v > $signed({34'd0, S32_MAX})) begin
      o = S32_MAX;
    end else if (v < $signed({{34{1'b1}}, S32_MIN})) begin
      o = S32_MIN;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

endpackage

// File: rtl/v3alu_if.sv
// Handshake interfaces for the vector unit: item channel and result channel.
// Each carries valid, ready and the payload; no dependencies.
`timescale 1ns / 1ps

interface v3alu_item_if;
  logic              valid;
  logic              ready;
  logic [3:0]        opcode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;
  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                output ready);
endinterface

interface v3alu_result_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_scalar;
  logic              div_zero;
  modport source (output valid, r_x, r_y, r_z, r_scalar, div_zero, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_scalar, div_zero, output ready);
endinterface

// File: rtl/vector3_alu.sv
// Top level of the three-component Q16.16 vector unit.
// Depends on v3alu_pkg, v3alu_if, v3alu_front, v3alu_sqrt and v3alu_div.
//
// Usage: items arrive on the item channel (opcode, vectors A and B, scalar)
// and each yields exactly one result on the result channel (vector, scalar,
// divide-by-zero flag). A transfer happens on a rising clk edge with valid
// and ready both high. Opcodes 11 to 15 give an all-zero result.
//
// An item passes from its transfer to its result through 4 front stages
// (multiply, sum, saturate and normalize), 32 square root stages producing
// one root bit each, 2 divider set-up stages, 32 divider stages producing
// one quotient bit each, and the output register. Throughput is one item
// per cycle except while frozen; every stage is a plain register stage.
//
// The output register has a one-entry skid buffer behind it. When the
// receiver holds ready low, the next finished result parks in the skid
// buffer; only once that buffer is occupied does the whole pipeline freeze
// and item ready drop, so nothing is lost or repeated. Synchronous reset
// (rst high) clears every valid bit; payload registers are not reset.
`timescale 1ns / 1ps

module vector3_alu
  import v3alu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  v3alu_item_if.sink     item,
  v3alu_result_if.source result
);

  // The pipeline advances whenever the skid buffer is free.
  logic      en;
  logic      skid_v;
  res_t      skid_d;
  logic      out_v;
  res_t      out_d;

  assign en         = !skid_v;
  assign item.ready = en;

  logic      f_vld;
  logic [63:0] f_x;
  sq_carry_t f_c;

  v3alu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (item.valid),
    .opcode    (item.opcode),
    .a_x       (item.a_x),
    .a_y       (item.a_y),
    .a_z       (item.a_z),
    .b_x       (item.b_x),
    .b_y       (item.b_y),
    .b_z       (item.b_z),
    .scalar_in (item.scalar_in),
    .out_vld   (f_vld),
    .sq_x      (f_x),
    .carry     (f_c)
  );

  // The square root of the normalized squared norm serves both the length
  // op (shifted back down) and the divisor for set-length and normalize.
  logic        s_vld;
  logic [31:0] s_root;
  sq_carry_t   s_c;

  v3alu_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .x       (f_x),
    .cin     (f_c),
    .out_vld (s_vld),
    .root    (s_root),
    .cout    (s_c)
  );

  logic             d_vld;
  logic [2:0][31:0] d_q;
  logic [2:0]       d_ovf;
  dv_carry_t        d_c;

  v3alu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_vld),
    .d_in    (s_root),
    .cin     (s_c),
    .out_vld (d_vld),
    .q       (d_q),
    .ovf     (d_ovf),
    .cout    (d_c)
  );

  // Apply the quotient sign and saturate. A magnitude of 2^31 or more
  // pins to the limit on the side of the sign.
  res_t fin;
  logic big;

  always_comb begin
    fin = d_c.res;
    big = 1'b0;
    if (d_c.use_div) begin
      for (int i = 0; i < 3; i++) begin
        big = d_ovf[i] || d_q[i][31];
        if (d_c.neg[i]) begin
          fin.r[i] = big ? S32_MIN : (~d_q[i] + 32'd1);
        end else begin
          fin.r[i] = big ? S32_MAX : d_q[i];
        end
      end
    end
  end

  // Output register with skid buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || result.ready) begin
      out_v  <= skid_v || d_vld;
      skid_v <= 1'b0;
    end else if (d_vld) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || result.ready) begin
      out_d <= skid_v ? skid_d : fin;
    end else if (!skid_v) begin
      skid_d <= fin;
    end
  end

  assign result.valid    = out_v;
  assign result.r_x      = out_d.r[0];
  assign result.r_y      = out_d.r[1];
  assign result.r_z      = out_d.r[2];
  assign result.r_scalar = out_d.rs;
  assign result.div_zero = out_d.dz;

  // The skid buffer only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid buffer holds a result while the output register is empty");

  // A parked result must not move or vanish while the receiver stalls.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !result.ready) |=> (skid_v && $stable(skid_d)))
    else $error("skid buffer changed during a stall");

  // Only the divide op raises the flag, and it never carries a scalar result.
  a_dz_scalar: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_d.dz) |-> (out_d.rs == '0))
    else $error("divide-by-zero result carries a nonzero scalar");

endmodule

// File: rtl/v3alu_front.sv
// Front section of the vector unit: multipliers, product sums, simple results
// and normalization of the squared norm. Four register stages; uses v3alu_pkg.
`timescale 1ns / 1ps

module v3alu_front
  import v3alu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [3:0]        opcode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] scalar_in,
  output logic              out_vld,
  output logic [63:0]       sq_x,
  output sq_carry_t         carry
);

  logic signed [31:0] a_in [3];
  logic signed [31:0] b_in [3];
  logic signed [31:0] y_sel [3];
  logic signed [31:0] t_sel;
  logic signed [63:0] xp_n [3];
  logic signed [63:0] tp_n [3];
  logic signed [63:0] cp_n [6];
  res_t               res1_n;

  assign a_in[0] = a_x;
  assign a_in[1] = a_y;
  assign a_in[2] = a_z;
  assign b_in[0] = b_x;
  assign b_in[1] = b_y;
  assign b_in[2] = b_z;

  // Cross product terms.
  assign cp_n[0] = a_in[1] * b_in[2];
  assign cp_n[1] = a_in[2] * b_in[1];
  assign cp_n[2] = a_in[2] * b_in[0];
  assign cp_n[3] = a_in[0] * b_in[2];
  assign cp_n[4] = a_in[0] * b_in[1];
  assign cp_n[5] = a_in[1] * b_in[0];

  always_comb begin
    t_sel  = (opcode == OP_NORM) ? Q_ONE : scalar_in;
    res1_n = '0;
    for (int i = 0; i < 3; i++) begin
      y_sel[i] = (opcode == OP_DOT) ? b_in[i] : a_in[i];
      xp_n[i]  = a_in[i] * y_sel[i];
      tp_n[i]  = a_in[i] * t_sel;
      case (opcode)
        OP_ADD: res1_n.r[i] = sat66(66'(a_in[i]) + 66'(b_in[i]));
        OP_SUB: res1_n.r[i] = sat66(66'(a_in[i]) - 66'(b_in[i]));
        OP_NEG: res1_n.r[i] = sat66(-66'(a_in[i]));
        OP_DIV: begin
          if (scalar_in == '0) begin
            if (a_in[i] > 0) begin
              res1_n.r[i] = S32_MAX;
            end else if (a_in[i] < 0) begin
              res1_n.r[i] = S32_MIN;
            end
          end
        end
        default: res1_n.r[i] = '0;
      endcase
    end
    res1_n.dz = (opcode == OP_DIV) && (scalar_in == '0);
  end

  // Stage 1: products.
  logic               v1;
  logic [3:0]         op1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] s1;
  logic signed [63:0] xp1 [3];
  logic signed [63:0] tp1 [3];
  logic signed [63:0] cp1 [6];
  res_t               res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= opcode;
      a1   <= a_in;
      s1   <= scalar_in;
      xp1  <= xp_n;
      tp1  <= tp_n;
      cp1  <= cp_n;
      res1 <= res1_n;
    end
  end

  // Stage 2: sums of products.
  logic               v2;
  logic [3:0]         op2;
  logic signed [31:0] a2 [3];
  logic signed [31:0] s2;
  logic signed [63:0] tp2 [3];
  logic [63:0]        ss2;
  logic signed [65:0] dot2;
  logic signed [64:0] crs2 [3];
  res_t               res2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2     <= op1;
      a2      <= a1;
      s2      <= s1;
      tp2     <= tp1;
      ss2     <= 64'(xp1[0]) + 64'(xp1[1]) + 64'(xp1[2]);
      dot2    <= 66'(xp1[0]) + 66'(xp1[1]) + 66'(xp1[2]);
      crs2[0] <= 65'(cp1[0]) - 65'(cp1[1]);
      crs2[1] <= 65'(cp1[2]) - 65'(cp1[3]);
      crs2[2] <= 65'(cp1[4]) - 65'(cp1[5]);
      res2    <= res1;
    end
  end

  // Stage 3: floor and saturate the product ops; first half of normalization.
  res_t        res3_n;
  logic [63:0] sn3_n;
  logic [4:0]  m3_n;

  always_comb begin
    res3_n = res2;
    case (op2)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          res3_n.r[i] = sat66(66'(tp2[i] >>> 16));
        end
      end
      OP_DOT:   res3_n.rs = sat66(dot2 >>> 16);
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          res3_n.r[i] = sat66(66'(crs2[i] >>> 16));
        end
      end
      OP_NORMSQ: res3_n.rs = (ss2[63:47] != '0) ? S32_MAX : {1'b0, ss2[46:16]};
      OP_SETLEN, OP_NORM: begin
        if (ss2 == '0) begin
          for (int i = 0; i < 3; i++) begin
            res3_n.r[i] = a2[i];
          end
        end
      end
      default: res3_n = res2;
    endcase

    sn3_n = ss2;
    m3_n  = '0;
    if (sn3_n[63:32] == '0) begin
      sn3_n = {sn3_n[31:0], 32'd0};
      m3_n  = m3_n + 5'd16;
    end
    if (sn3_n[63:48] == '0) begin
      sn3_n = {sn3_n[47:0], 16'd0};
      m3_n  = m3_n + 5'd8;
    end
    if (sn3_n[63:56] == '0) begin
      sn3_n = {sn3_n[55:0], 8'd0};
      m3_n  = m3_n + 5'd4;
    end
  end

  logic               v3;
  logic [3:0]         op3;
  logic signed [31:0] a3 [3];
  logic signed [31:0] s3;
  logic signed [63:0] tp3 [3];
  logic               ssz3;
  logic [63:0]        sn3;
  logic [4:0]         m3;
  res_t               res3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3  <= op2;
      a3   <= a2;
      s3   <= s2;
      tp3  <= tp2;
      ssz3 <= (ss2 == '0);
      sn3  <= sn3_n;
      m3   <= m3_n;
      res3 <= res3_n;
    end
  end

  // Stage 4: finish normalization and set up the divider operands.
  logic [63:0] sn4_n;
  logic [4:0]  m4_n;
  sq_carry_t   c4_n;
  logic [63:0] tmag;
  logic [31:0] amag;

  always_comb begin
    sn4_n = sn3;
    m4_n  = m3;
    if (sn4_n[63:60] == '0) begin
      sn4_n = {sn4_n[59:0], 4'd0};
      m4_n  = m4_n + 5'd2;
    end
    if (sn4_n[63:62] == '0) begin
      sn4_n = {sn4_n[61:0], 2'd0};
      m4_n  = m4_n + 5'd1;
    end

    c4_n         = '0;
    c4_n.res     = res3;
    c4_n.is_vdiv = (op3 == OP_DIV);
    c4_n.use_div = ((op3 == OP_DIV) && (s3 != '0)) ||
                   (((op3 == OP_SETLEN) || (op3 == OP_NORM)) && !ssz3);
    c4_n.is_len  = (op3 == OP_LEN) && !ssz3;
    c4_n.m       = m4_n;
    c4_n.ds      = s3[31] ? 32'(-s3) : 32'(s3);
    tmag         = '0;
    amag         = '0;
    for (int i = 0; i < 3; i++) begin
      if (op3 == OP_DIV) begin
        amag        = a3[i][31] ? 32'(-a3[i]) : 32'(a3[i]);
        c4_n.pm[i]  = {31'd0, amag};
        c4_n.neg[i] = a3[i][31] ^ s3[31];
      end else begin
        tmag        = tp3[i][63] ? 64'(-tp3[i]) : 64'(tp3[i]);
        c4_n.pm[i]  = tmag[62:0];
        c4_n.neg[i] = tp3[i][63];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= sn4_n;
      carry <= c4_n;
    end
  end

endmodule

// File: rtl/v3alu_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// with side data riding alongside. Uses v3alu_pkg.
`timescale 1ns / 1ps

module v3alu_sqrt
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] x,
  input  sq_carry_t   cin,
  output logic        out_vld,
  output logic [31:0] root,
  output sq_carry_t   cout
);

  logic        vld_s  [SQRT_STEPS+1];
  logic [32:0] rem_s  [SQRT_STEPS+1];
  logic [31:0] root_s [SQRT_STEPS+1];
  logic [63:0] xs_s   [SQRT_STEPS+1];
  sq_carry_t   c_s    [SQRT_STEPS+1];

  assign vld_s[0]  = in_vld;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign xs_s[0]   = x;
  assign c_s[0]    = cin;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        take;

    always_comb begin
      rem_sh = {rem_s[k], xs_s[k][63:62]};
      trial  = {1'b0, root_s[k], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= take ? 33'(rem_sh - trial) : rem_sh[32:0];
        root_s[k+1] <= {root_s[k][30:0], take};
        xs_s[k+1]   <= {xs_s[k][61:0], 2'b00};
        c_s[k+1]    <= c_s[k];
      end
    end
  end

  assign out_vld = vld_s[SQRT_STEPS];
  assign root    = root_s[SQRT_STEPS];
  assign cout    = c_s[SQRT_STEPS];

endmodule

// File: rtl/v3alu_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, with
// two set-up stages (dividend shift, overflow check) and the length result.
// Uses v3alu_pkg.
`timescale 1ns / 1ps

module v3alu_div
  import v3alu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [31:0]      d_in,
  input  sq_carry_t        cin,
  output logic             out_vld,
  output logic [2:0][31:0] q,
  output logic [2:0]       ovf,
  output dv_carry_t        cout
);

  // Set-up stage 1: shift dividends, pick divisor, finish the length op.
  logic [4:0]  sh;
  logic [93:0] nfull [3];
  logic [31:0] len;
  dv_carry_t   c1_n;

  always_comb begin
    sh   = cin.is_vdiv ? 5'd16 : cin.m;
    len  = d_in >> cin.m;
    c1_n = '{res: cin.res, use_div: cin.use_div, neg: cin.neg};
    if (cin.is_len) begin
      c1_n.res.rs = len[31] ? S32_MAX : len;
    end
    for (int i = 0; i < 3; i++) begin
      nfull[i] = 94'(cin.pm[i]) << sh;
    end
  end

  logic        v1;
  logic [61:0] nh1 [3];
  logic [31:0] nl1 [3];
  logic [31:0] dv1;
  dv_carry_t   c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nh1[i] <= nfull[i][93:32];
        nl1[i] <= nfull[i][31:0];
      end
      dv1 <= cin.is_vdiv ? cin.ds : d_in;
      c1  <= c1_n;
    end
  end

  // Set-up stage 2 feeds step 0: a quotient of 2^32 or more is flagged.
  logic             vld_s [DIV_STEPS+1];
  logic [2:0][31:0] rem_s [DIV_STEPS+1];
  logic [2:0][31:0] qd_s  [DIV_STEPS+1];
  logic [2:0]       ovf_s [DIV_STEPS+1];
  logic [31:0]      dv_s  [DIV_STEPS+1];
  dv_carry_t        c_s   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ovf_s[0][i] <= (nh1[i][61:32] != '0) || (nh1[i][31:0] >= dv1);
        rem_s[0][i] <= nh1[i][31:0];
        qd_s[0][i]  <= nl1[i];
      end
      dv_s[0] <= dv1;
      c_s[0]  <= c1;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [2:0][32:0] t;
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_s[k][i], qd_s[k][i][31]};
        ge[i] = (t[i] >= {1'b0, dv_s[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_s[k+1][i] <= ge[i] ? 32'(t[i] - {1'b0, dv_s[k]}) : t[i][31:0];
          qd_s[k+1][i]  <= {qd_s[k][i][30:0], ge[i]};
        end
        ovf_s[k+1] <= ovf_s[k];
        dv_s[k+1]  <= dv_s[k];
        c_s[k+1]   <= c_s[k];
      end
    end
  end

  assign out_vld = vld_s[DIV_STEPS];
  assign q       = qd_s[DIV_STEPS];
  assign ovf     = ovf_s[DIV_STEPS];
  assign cout    = c_s[DIV_STEPS];

endmodule

// File: verif/tb_vector3_alu.sv
// Self-checking testbench for vector3_alu: drives items on the item channel and checks
// every result against a bit-exact Q16.16 predictor of all eleven operations.
// Depends on v3alu_pkg, v3alu_if and the vector3_alu RTL.
`timescale 1ns / 1ps

module tb_vector3_alu;
  import v3alu_pkg::*;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  // One item as the sender sees it.
  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_item_t;

  // One result as the checker sees it.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sc;
    logic        dz;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  v3alu_item_if   item_ch ();
  v3alu_result_if res_ch ();

  vector3_alu dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always #6 clk = ~clk;

  vec_result_t pending_results [$];
  int          error_count = 0;
  bit          idle_on = 1'b1;   // random gaps and stalls on both sides
  int          hold_cycles = 0;  // one long receiver hold-off, consumed by the receiver

  // ---------------------------------------------------------------------------
  // Predictor. All intermediates are exact in 64 bits or wider but the floored root of
  // set-length and normalize; the final value is rounded and clamped to signed 32 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) begin
      return QMAX;
    end
    if (v < -66'sh8000_0000) begin
      return QMIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vec_result_t compute_vector_op(input vec_item_t it);
    vec_result_t        o;
    logic signed [65:0] ea [3];
    logic signed [65:0] eb [3];
    logic signed [65:0] es;
    logic signed [65:0] tgt;
    logic signed [65:0] w [3];
    logic signed [65:0] acc;
    logic [63:0]        ss;
    logic [63:0]        sn;
    logic [63:0]        d;
    logic [63:0]        p;
    logic [63:0]        mt;
    logic [127:0]       q;
    int                 m;
    bit                 neg;
    o = '{default: '0};
    w = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      ea[i] = it.a[i];
      eb[i] = it.b[i];
    end
    es  = it.s;
    acc = ea[0] * ea[0] + ea[1] * ea[1] + ea[2] * ea[2];
    ss  = acc[63:0];
    case (it.op)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) w[i] = ea[i] + eb[i];
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) w[i] = ea[i] - eb[i];
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++) w[i] = -ea[i];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) w[i] = (ea[i] * es) >>> 16;
      end
      OP_DIV: begin
        if (es == 0) begin
          o.dz = 1'b1;
          // A zero divisor pins each component to the rail of its own sign.
          for (int i = 0; i < 3; i++) w[i] = ea[i] > 0 ? 66'sh7FFF_FFFF :
                                             (ea[i] < 0 ? -66'sh8000_0000 : 66'sd0);
        end else begin
          for (int i = 0; i < 3; i++) w[i] = (ea[i] <<< 16) / es;
        end
      end
      OP_DOT: begin
        o.sc = clamp32((ea[0] * eb[0] + ea[1] * eb[1] + ea[2] * eb[2]) >>> 16);
      end
      OP_CROSS: begin
        w[0] = (ea[1] * eb[2] - ea[2] * eb[1]) >>> 16;
        w[1] = (ea[2] * eb[0] - ea[0] * eb[2]) >>> 16;
        w[2] = (ea[0] * eb[1] - ea[1] * eb[0]) >>> 16;
      end
      OP_LEN: begin
        d    = root_floor(ss);
        o.sc = d > 64'h7FFF_FFFF ? QMAX : d[31:0];
      end
      OP_NORMSQ: begin
        o.sc = (ss >> 16) > 64'h7FFF_FFFF ? QMAX : ss[47:16];
      end
      OP_SETLEN, OP_NORM: begin
        tgt = (it.op == OP_NORM) ? 66'sd65536 : es;
        if (ss == 0) begin
          // A zero-length vector passes through untouched.
          for (int i = 0; i < 3; i++) w[i] = ea[i];
        end else begin
          sn = ss;
          m  = 0;
          while (sn < 64'h4000_0000_0000_0000) begin
            sn = sn << 2;
            m++;
          end
          d  = root_floor(sn);
          mt = tgt < 0 ? 64'(-tgt) : 64'(tgt);
          for (int i = 0; i < 3; i++) begin
            p   = ea[i] < 0 ? 64'(-ea[i]) : 64'(ea[i]);
            p   = p * mt;
            q   = ({64'd0, p} << m) / {64'd0, d};
            neg = (ea[i] < 0) != (tgt < 0);
            if (neg) begin
              w[i] = q >= 128'h8000_0000 ? -66'sh8000_0000 : -$signed({2'b0, q[63:0]});
            end else begin
              w[i] = q > 128'h7FFF_FFFF ? 66'sh7FFF_FFFF : $signed({2'b0, q[63:0]});
            end
          end
        end
      end
      default: begin
      end
    endcase
    o.x = clamp32(w[0]);
    o.y = clamp32(w[1]);
    o.z = clamp32(w[2]);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the rising edge of the transfer
  // with valid still high, so back-to-back items follow with no idle gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input vec_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.opcode    <= it.op;
    item_ch.a_x       <= it.a[0];
    item_ch.a_y       <= it.a[1];
    item_ch.a_z       <= it.a[2];
    item_ch.b_x       <= it.b[0];
    item_ch.b_y       <= it.b[1];
    item_ch.b_z       <= it.b[2];
    item_ch.scalar_in <= it.s;
    pending_results.push_back(compute_vector_op(it));
    // Ready only changes at rising edges, so the value at the falling edge is
    // the value seen by the next rising edge.
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
  endtask

  task automatic stop_sending();
    item_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    stop_sending();
    wait (pending_results.size() == 0);
    // Let the last result leave the output register before anything else.
    repeat (80) @(posedge clk);
  endtask

  function automatic vec_item_t make_item(input logic [3:0] op,
                                          input logic signed [31:0] ax, ay, az,
                                          input logic signed [31:0] bx, by, bz,
                                          input logic signed [31:0] s);
    vec_item_t it;
    it.op = op;
    it.a  = '{ax, ay, az};
    it.b  = '{bx, by, bz};
    it.s  = s;
    return it;
  endfunction

  // Mix of full-range, moderate, small and rail values so that results are
  // not all saturated and every bit still toggles.
  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      3: return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return 32'sd0;
          3: return 32'sd65536;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t it;
    it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                         : 4'($urandom_range(0, 10));
    for (int i = 0; i < 3; i++) begin
      it.a[i] = rand_fixed();
      it.b[i] = rand_fixed();
    end
    it.s = rand_fixed();
    // A zero vector now and then exercises the pass-through of set-length and normalize.
    if ((it.op == OP_SETLEN || it.op == OP_NORM) && $urandom_range(0, 9) == 0) begin
      it.a = '{32'sd0, 32'sd0, 32'sd0};
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    idle_on = 1'b0;
    send_item(make_item(OP_ADD, QMAX, QMIN, 1, 1, -1, -1, 0));
    send_item(make_item(OP_ADD, QMIN, QMAX, 0, QMIN, QMAX, 0, 0));
    send_item(make_item(OP_SUB, QMAX, QMIN, 5, -1, 1, 5, 0));
    send_item(make_item(OP_NEG, QMIN, QMAX, 0, 0, 0, 0, 0));
    send_item(make_item(OP_SCALE, QMAX, QMIN, -3, 0, 0, 0, QMAX));
    send_item(make_item(OP_SCALE, 65536, -65536, -1, 0, 0, 0, 32768));
    send_item(make_item(OP_DIV, 7, -7, 0, 0, 0, 0, 0));
    send_item(make_item(OP_DIV, QMAX, QMIN, -65536, 0, 0, 0, 1));
    send_item(make_item(OP_DIV, QMIN, 3, -3, 0, 0, 0, -1));
    send_item(make_item(OP_DIV, 65536, -65536, 100, 0, 0, 0, 196608));
    send_item(make_item(OP_DOT, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0));
    send_item(make_item(OP_DOT, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0));
    send_item(make_item(OP_DOT, -1, 1, -1, 1, 1, 1, 0));
    send_item(make_item(OP_CROSS, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 0));
    send_item(make_item(OP_CROSS, 65536, 0, 0, 0, 65536, 0, 0));
    send_item(make_item(OP_LEN, QMIN, QMIN, QMIN, 0, 0, 0, 0));
    send_item(make_item(OP_LEN, 196608, 262144, 0, 0, 0, 0, 0));
    send_item(make_item(OP_NORMSQ, QMIN, QMIN, QMIN, 0, 0, 0, 0));
    send_item(make_item(OP_NORMSQ, 1, -1, 256, 0, 0, 0, 0));
    send_item(make_item(OP_SETLEN, 0, 0, 0, 0, 0, 0, QMAX));
    send_item(make_item(OP_SETLEN, 1, 0, -1, 0, 0, 0, QMIN));
    send_item(make_item(OP_SETLEN, QMIN, QMAX, 3, 0, 0, 0, QMAX));
    send_item(make_item(OP_NORM, 0, 0, 0, 1, 2, 3, 4));
    send_item(make_item(OP_NORM, -1, 0, 0, 0, 0, 0, 0));
    send_item(make_item(4'd11, QMAX, QMIN, 1, 1, 1, 1, 1));
    send_item(make_item(4'd15, -1, -1, -1, -1, -1, -1, -1));
    wait_for_drain();
  endtask

  task automatic test_random_stream(input int count);
    for (int n = 0; n < count; n++) begin
      // Alternate stretches with random idling and stretches at full rate.
      if (n % 150 == 0) idle_on = (n / 150) % 3 != 2;
      send_item(rand_item());
    end
    wait_for_drain();
  endtask

  // The receiver holds off long enough for the pipe and the skid buffer to
  // fill, so item ready must drop while the sender keeps offering.
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 300;
    for (int n = 0; n < 200; n++) send_item(rand_item());
    idle_on = 1'b1;
    wait_for_drain();
  endtask

  // Sender pauses mid-stream until every outstanding result has come back.
  task automatic test_drain_pause();
    idle_on = 1'b1;
    for (int n = 0; n < 60; n++) send_item(rand_item());
    wait_for_drain();
    for (int n = 0; n < 60; n++) send_item(rand_item());
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall per result, plus the one-time long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      stall += hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(negedge clk); while (!res_ch.valid);
      @(posedge clk);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
  endtask

  // Checker: a transfer is seen at the falling edge before the edge that takes it.
  initial begin
    vec_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t result transfer with nothing outstanding", $realtime);
        end else begin
          want = pending_results.pop_front();
          if (res_ch.r_x !== want.x) report_mismatch("r_x", res_ch.r_x, want.x);
          if (res_ch.r_y !== want.y) report_mismatch("r_y", res_ch.r_y, want.y);
          if (res_ch.r_z !== want.z) report_mismatch("r_z", res_ch.r_z, want.z);
          if (res_ch.r_scalar !== want.sc) report_mismatch("r_scalar", res_ch.r_scalar, want.sc);
          if (res_ch.div_zero !== want.dz) report_mismatch("div_zero", res_ch.div_zero, want.dz);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    item_ch.valid     = 1'b0;
    item_ch.opcode    = '0;
    item_ch.a_x       = '0;
    item_ch.a_y       = '0;
    item_ch.a_z       = '0;
    item_ch.b_x       = '0;
    item_ch.b_y       = '0;
    item_ch.b_z       = '0;
    item_ch.scalar_in = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream(1000);
    test_backpressure();
    test_drain_pause();
    if (pending_results.size() != 0) begin
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_vector3_alu: done, clean");
    end else begin
      $display("tb_vector3_alu: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_vector3_alu: done, errors");
    $finish;
  end

endmodule
